// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/es2cal_pkg.sv =====
// ----------------------------------------------------------------------------
// es2cal_pkg
// Types, constants and helpers for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package es2cal_pkg;

  localparam int SECONDS_WIDTH_DEF = 32;

  // seconds into the current year stay below one leap year, under 2**25
  localparam int SOY_W = 25;
  localparam logic [SOY_W-1:0] SECS_COMMON_YEAR = 25'd31536000;  // 365 days
  localparam logic [SOY_W-1:0] SECS_LEAP_YEAR   = 25'd31622400;  // 366 days
  localparam logic [SOY_W-1:0] SECS_PER_DAY     = 25'd86400;
  localparam logic [16:0]      SECS_PER_HOUR    = 17'd3600;
  localparam logic [11:0]      SECS_PER_MIN     = 12'd60;

  // x / (2**s * d) = ((x >> s) * ceil(2**k / d)) >> k, exact over each input range
  localparam logic [18:0] RCP_DAY  = 19'd397683;  // 86400 = 2**7 * 675, k = 28
  localparam int          SH_DAY   = 28;
  localparam logic [13:0] RCP_HOUR = 14'd9321;    // 3600 = 2**4 * 225, k = 21
  localparam int          SH_HOUR  = 21;
  localparam logic [10:0] RCP_MIN  = 11'd1093;    // 60 = 2**2 * 15, k = 14
  localparam int          SH_MIN   = 14;
  localparam logic [9:0]  RCP_WEEK = 10'd586;     // 7, k = 12
  localparam int          SH_WEEK  = 12;

  localparam logic [8:0] LEAP_DAY    = 9'd59;   // day of year of 29 February

  // position of the year inside the 400-year Gregorian cycle
  localparam logic [8:0] CYCLE_LEN      = 9'd400;
  localparam logic [8:0] CYCLE_CENT1    = 9'd100;
  localparam logic [8:0] CYCLE_CENT2    = 9'd200;
  localparam logic [8:0] CYCLE_CENT3    = 9'd300;
  localparam logic [8:0] BASE_CYCLE_POS = 9'd370;  // 1970 mod 400
  localparam logic [7:0] BASE_YEAR_OFS  = 8'd70;   // 1970 - 1900

  localparam logic [2:0] DAYS_PER_WEEK = 3'd7;
  localparam logic [2:0] EPOCH_WEEKDAY = 3'd4;     // Thursday

  localparam int MONTHS = 12;
  localparam logic [8:0] MONTH_START [MONTHS] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_DAY,
    ST_TOD,
    ST_HOUR,
    ST_HREM,
    ST_MIN,
    ST_MONTH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic year_step;
    logic lat_day;
    logic lat_tod;
    logic lat_hour;
    logic lat_hrem;
    logic lat_min;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic year_done;
  } status_t;

  // month of a non-leap day of year
  function automatic logic [3:0] month_of(input logic [8:0] w);
    logic [3:0] m;
    m = '0;
    for (int i = 1; i < MONTHS; i++) begin
      if (w >= MONTH_START[i]) m = 4'(i);
    end
    return m;
  endfunction

endpackage

// ===== hdl/epoch_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Unsigned epoch seconds to broken-down UTC calendar date and time.
// ----------------------------------------------------------------------------
//   channel | dir | handshake          | fields
//   in_     | in  | in_valid/in_stall   | epoch_seconds
//   out_    | out | out_valid/out_stall | second minute hour weekday
//           |     |                     | years_since_1900 day_of_year month
//           |     |                     | day_of_month
//
// One request at a time: the year loop runs once per whole year past 1970, taking
// one year of seconds off per cycle, before the steps below lead to out_valid.
// Day, time-of-day and weekday splits then take five reciprocal and remainder steps, month one.
// in_stall is high from accept until the result is in the output register.
// A result held by out_stall does not block the next accept.
// Synchronous active-low reset clears the controller only.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar #(
  parameter int SECONDS_WIDTH = es2cal_pkg::SECONDS_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SECONDS_WIDTH-1:0] in_epoch_seconds,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [5:0]               out_second,
  output logic [5:0]               out_minute,
  output logic [4:0]               out_hour,
  output logic [2:0]               out_weekday,
  output logic [7:0]               out_years_since_1900,
  output logic [8:0]               out_day_of_year,
  output logic [3:0]               out_month,
  output logic [4:0]               out_day_of_month
);

  es2cal_pkg::cmd_t    cmd;
  es2cal_pkg::status_t status;

  es2cal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  es2cal_dp #(
    .SECONDS_WIDTH(SECONDS_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .in_epoch_seconds     (in_epoch_seconds),
    .cmd                  (cmd),
    .status               (status),
    .out_second           (out_second),
    .out_minute           (out_minute),
    .out_hour             (out_hour),
    .out_weekday          (out_weekday),
    .out_years_since_1900 (out_years_since_1900),
    .out_day_of_year      (out_day_of_year),
    .out_month            (out_month),
    .out_day_of_month     (out_day_of_month)
  );

endmodule

// ===== hdl/es2cal_dp.sv =====
// ----------------------------------------------------------------------------
// es2cal_dp
// Datapath: year stepper, reciprocal splits, month lookup and result registers.
// ----------------------------------------------------------------------------
module es2cal_dp #(
  parameter int SECONDS_WIDTH = es2cal_pkg::SECONDS_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic [SECONDS_WIDTH-1:0] in_epoch_seconds,
  input  es2cal_pkg::cmd_t         cmd,
  output es2cal_pkg::status_t      status,
  output logic [5:0]               out_second,
  output logic [5:0]               out_minute,
  output logic [4:0]               out_hour,
  output logic [2:0]               out_weekday,
  output logic [7:0]               out_years_since_1900,
  output logic [8:0]               out_day_of_year,
  output logic [3:0]               out_month,
  output logic [4:0]               out_day_of_month
);

  localparam int SOY_W = es2cal_pkg::SOY_W;

  logic [SECONDS_WIDTH-1:0] secs_r;
  logic [8:0]               cyc_r;
  logic [7:0]               yofs_r;
  logic [2:0]               wk_r;     // weekday of 1 January of the current year
  logic [8:0]               yday_r;
  logic [16:0]              tod_r;
  logic [2:0]               wday_r;
  logic [4:0]               hour_r;
  logic [11:0]              hrem_r;
  logic [5:0]               min_r;

  // year stepping
  logic             leap;
  logic [SOY_W-1:0] year_secs;
  logic [8:0]       cyc_inc;
  logic [3:0]       wk_sum;
  logic [2:0]       wk_nxt;

  assign leap = (cyc_r[1:0] == 2'b00) && (cyc_r != es2cal_pkg::CYCLE_CENT1)
             && (cyc_r != es2cal_pkg::CYCLE_CENT2) && (cyc_r != es2cal_pkg::CYCLE_CENT3);
  assign year_secs = leap ? es2cal_pkg::SECS_LEAP_YEAR : es2cal_pkg::SECS_COMMON_YEAR;
  assign cyc_inc   = (cyc_r == es2cal_pkg::CYCLE_LEN - 9'd1) ? 9'd0 : cyc_r + 9'd1;
  // a common year moves 1 January on by one weekday, a leap year by two
  assign wk_sum    = {1'b0, wk_r} + (leap ? 4'd2 : 4'd1);
  assign wk_nxt    = (wk_sum >= {1'b0, es2cal_pkg::DAYS_PER_WEEK})
                   ? 3'(wk_sum - {1'b0, es2cal_pkg::DAYS_PER_WEEK}) : wk_sum[2:0];
  assign status.year_done = (secs_r < SECONDS_WIDTH'(year_secs));

  // day, time of day and weekday splits
  logic [SOY_W-1:0] soy;
  logic [36:0]      day_prod;
  logic [SOY_W-1:0] day_secs;
  logic [8:0]       wsum;
  logic [18:0]      wk_prod;
  logic [8:0]       wq_x7;
  logic [25:0]      hr_prod;
  logic [16:0]      hr_secs;
  logic [20:0]      min_prod;
  logic [11:0]      min_secs;

  assign soy      = secs_r[SOY_W-1:0];
  assign day_prod = 37'(soy[SOY_W-1:7]) * 37'(es2cal_pkg::RCP_DAY);
  assign day_secs = SOY_W'(yday_r) * es2cal_pkg::SECS_PER_DAY;
  assign wsum     = yday_r + {6'd0, wk_r};
  assign wk_prod  = 19'(wsum) * 19'(es2cal_pkg::RCP_WEEK);
  assign wq_x7    = 9'(wk_prod >> es2cal_pkg::SH_WEEK) * 9'(es2cal_pkg::DAYS_PER_WEEK);
  assign hr_prod  = 26'(tod_r[16:4]) * 26'(es2cal_pkg::RCP_HOUR);
  assign hr_secs  = 17'(hour_r) * es2cal_pkg::SECS_PER_HOUR;
  assign min_prod = 21'(hrem_r[11:2]) * 21'(es2cal_pkg::RCP_MIN);
  assign min_secs = 12'(min_r) * es2cal_pkg::SECS_PER_MIN;

  // month and day of month
  logic       past_feb;
  logic [8:0] wdn;
  logic [3:0] mon;
  logic [4:0] mday_base;
  logic [4:0] mday;

  assign past_feb  = leap && (yday_r >= es2cal_pkg::LEAP_DAY);
  assign wdn       = past_feb ? yday_r - 9'd1 : yday_r;
  assign mon       = es2cal_pkg::month_of(wdn);
  assign mday_base = (leap && (yday_r == es2cal_pkg::LEAP_DAY)) ? 5'd2 : 5'd1;
  assign mday      = mday_base + 5'(wdn - es2cal_pkg::MONTH_START[mon]);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      secs_r <= in_epoch_seconds;
      cyc_r  <= es2cal_pkg::BASE_CYCLE_POS;
      yofs_r <= es2cal_pkg::BASE_YEAR_OFS;
      wk_r   <= es2cal_pkg::EPOCH_WEEKDAY;
    end
    if (cmd.year_step) begin
      secs_r <= secs_r - SECONDS_WIDTH'(year_secs);
      cyc_r  <= cyc_inc;
      yofs_r <= yofs_r + 8'd1;
      wk_r   <= wk_nxt;
    end
    if (cmd.lat_day) yday_r <= 9'(day_prod >> es2cal_pkg::SH_DAY);
    if (cmd.lat_tod) begin
      tod_r  <= 17'(soy - day_secs);
      wday_r <= 3'(wsum - wq_x7);
    end
    if (cmd.lat_hour) hour_r <= 5'(hr_prod >> es2cal_pkg::SH_HOUR);
    if (cmd.lat_hrem) hrem_r <= 12'(tod_r - hr_secs);
    if (cmd.lat_min)  min_r  <= 6'(min_prod >> es2cal_pkg::SH_MIN);
    if (cmd.out_load) begin
      out_second           <= 6'(hrem_r - min_secs);
      out_minute           <= min_r;
      out_hour             <= hour_r;
      out_weekday          <= wday_r;
      out_years_since_1900 <= yofs_r;
      out_day_of_year      <= yday_r;
      out_month            <= mon;
      out_day_of_month     <= mday;
    end
  end

endmodule

// ===== hdl/es2cal_ctrl.sv =====
// ----------------------------------------------------------------------------
// es2cal_ctrl
// Controller: sequences year, split and month steps; owns handshakes.
// ----------------------------------------------------------------------------
module es2cal_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  es2cal_pkg::status_t status,
  output es2cal_pkg::cmd_t    cmd
);

  es2cal_pkg::state_t state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;
  logic               in_acc;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != es2cal_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      es2cal_pkg::ST_IDLE:  if (in_valid) state_nxt = es2cal_pkg::ST_YEAR;
      es2cal_pkg::ST_YEAR:  if (status.year_done) state_nxt = es2cal_pkg::ST_DAY;
      es2cal_pkg::ST_DAY:   state_nxt = es2cal_pkg::ST_TOD;
      es2cal_pkg::ST_TOD:   state_nxt = es2cal_pkg::ST_HOUR;
      es2cal_pkg::ST_HOUR:  state_nxt = es2cal_pkg::ST_HREM;
      es2cal_pkg::ST_HREM:  state_nxt = es2cal_pkg::ST_MIN;
      es2cal_pkg::ST_MIN:   state_nxt = es2cal_pkg::ST_MONTH;
      es2cal_pkg::ST_MONTH: if (out_free) state_nxt = es2cal_pkg::ST_IDLE;
      default:              state_nxt = es2cal_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load_in   = in_acc;
    cmd.year_step = (state_r == es2cal_pkg::ST_YEAR) && !status.year_done;
    cmd.lat_day   = (state_r == es2cal_pkg::ST_DAY);
    cmd.lat_tod   = (state_r == es2cal_pkg::ST_TOD);
    cmd.lat_hour  = (state_r == es2cal_pkg::ST_HOUR);
    cmd.lat_hrem  = (state_r == es2cal_pkg::ST_HREM);
    cmd.lat_min   = (state_r == es2cal_pkg::ST_MIN);
    cmd.out_load  = (state_r == es2cal_pkg::ST_MONTH) && out_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= es2cal_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/es2cal_chk.sv =====
// ----------------------------------------------------------------------------
// es2cal_chk
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module es2cal_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] out_second,
  input logic [5:0] out_minute,
  input logic [4:0] out_hour,
  input logic [2:0] out_weekday,
  input logic [8:0] out_day_of_year,
  input logic [3:0] out_month,
  input logic [4:0] out_day_of_month
);

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `ASSERT_SAME(a_fields_in_range, out_valid, (out_second < 6'd60) && (out_minute < 6'd60) && (out_hour < 5'd24) && (out_weekday < 3'd7) && (out_month < 4'd12) && (out_day_of_month != 5'd0))
  // January is the first 31 days of every year
  `ASSERT_SAME(a_january, out_valid, (out_month == 4'd0) == (out_day_of_year < 9'd31))

endmodule

bind epoch_seconds_to_calendar es2cal_chk u_chk (.*);

// ===== verif/epoch_seconds_to_calendar_tb.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb
// Self-checking bench for the epoch seconds to UTC calendar converter. A short
// table of boundary timestamps (epoch start, end of range, leap days, century
// years, year ends) runs first, then random requests biased toward year and
// leap-day boundaries. Each result is checked field by field, against values
// typed into the table or an in-bench Gregorian predictor, with random gaps
// and stalls on both sides and one long output hold that backs the block up.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_REQUESTS = 2000;
  localparam int unsigned CYCLE_LIMIT     = 4_000_000;
  localparam int unsigned DRAIN_CYCLES    = 300;
  localparam int unsigned HOLD_CYCLES     = 1500;
  localparam int unsigned HOLD_AFTER      = 300;   // results before the long hold

  localparam logic [31:0] SECS_PER_DAY = 32'd86400;
  localparam int unsigned SECS_PER_MIN = 60;
  localparam int unsigned SECS_PER_HR  = 3600;
  localparam int unsigned EPOCH_YEAR   = 1970;
  localparam int unsigned YEAR_OFS     = 1900;
  localparam int unsigned EPOCH_WDAY   = 4;        // 1970-01-01 was a Thursday
  localparam int unsigned LAST_FULL_YR = 2105;

  localparam int unsigned FIRST_YDAY [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] years_since_1900;
    logic [8:0] day_of_year;
    logic [3:0] month;
    logic [4:0] day_of_month;
  } cal_t;

  typedef struct {
    logic [31:0] secs;
    bit          typed;
    cal_t        want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_second;
  logic [5:0]  out_minute;
  logic [4:0]  out_hour;
  logic [2:0]  out_weekday;
  logic [7:0]  out_years_since_1900;
  logic [8:0]  out_day_of_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;

  cal_t        cal_q [$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned results_seen = 0;
  int unsigned leap_days_seen = 0;
  int unsigned cycle_cnt = 0;
  int unsigned min_year = 255;
  int unsigned max_year = 0;

  epoch_seconds_to_calendar dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  function automatic bit gregorian_leap(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  function automatic cal_t calendar_of(input logic [31:0] secs);
    cal_t        c;
    logic [16:0] tod;
    logic [31:0] days;
    int unsigned yr;
    int unsigned len;
    int unsigned w;
    int unsigned m;
    int unsigned md;
    tod = 17'(secs % SECS_PER_DAY);
    days = secs / SECS_PER_DAY;
    c.second  = 6'(tod % SECS_PER_MIN);
    c.minute  = 6'((tod / SECS_PER_MIN) % SECS_PER_MIN);
    c.hour    = 5'(tod / SECS_PER_HR);
    c.weekday = 3'((days + EPOCH_WDAY) % 7);
    yr = EPOCH_YEAR;
    len = gregorian_leap(yr) ? 366 : 365;
    while (days >= len) begin
      days -= len;
      yr++;
      len = gregorian_leap(yr) ? 366 : 365;
    end
    c.years_since_1900 = 8'(yr - YEAR_OFS);
    c.day_of_year = 9'(days);
    w = days;
    md = 1;
    // Feb 29 sits on Feb 28's table slot; later days shift back by one
    if (gregorian_leap(yr) && w > 58) begin
      if (w == 59) md = 2;
      w -= 1;
    end
    m = 11;
    while (m > 0 && FIRST_YDAY[m] > w) m--;
    c.month = 4'(m);
    c.day_of_month = 5'(md + w - FIRST_YDAY[m]);
    return c;
  endfunction

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned idle_len(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_request(input logic [31:0] secs, input cal_t want);
    int unsigned gap;
    gap = idle_len((sent / 100) % 5 == 2);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_epoch_seconds <= secs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cal_q.push_back(want);
    sent++;
  endtask

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  // output side: random stalls, one long hold once traffic is flowing
  initial begin : out_side
    bit          held;
    int unsigned n;
    held = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        n = idle_len((cycle_cnt / 4000) % 4 == 1);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    cal_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cal_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = cal_q.pop_front();
        check_field("second", want.second, out_second);
        check_field("minute", want.minute, out_minute);
        check_field("hour", want.hour, out_hour);
        check_field("weekday", want.weekday, out_weekday);
        check_field("years_since_1900", want.years_since_1900, out_years_since_1900);
        check_field("day_of_year", want.day_of_year, out_day_of_year);
        check_field("month", want.month, out_month);
        check_field("day_of_month", want.day_of_month, out_day_of_month);
        results_seen++;
        if (want.month == 1 && want.day_of_month == 29) leap_days_seen++;
        if (want.years_since_1900 < min_year) min_year = want.years_since_1900;
        if (want.years_since_1900 > max_year) max_year = want.years_since_1900;
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    row_t dir_rows [19];
    logic [31:0]     secs;
    longint unsigned cand;
    int unsigned     yr;
    int unsigned     y;
    int unsigned     yd;
    int unsigned     kind;
    dir_rows = '{
      // epoch start: Thursday 1970-01-01 00:00:00
      '{32'd0, 1'b1, '{6'd0, 6'd0, 5'd0, 3'd4, 8'd70, 9'd0, 4'd0, 5'd1}},
      '{32'd86399, 1'b1, '{6'd59, 6'd59, 5'd23, 3'd4, 8'd70, 9'd0, 4'd0, 5'd1}},
      // end of range: Sunday 2106-02-07 06:28:15
      '{32'hFFFF_FFFF, 1'b1, '{6'd15, 6'd28, 5'd6, 3'd0, 8'd206, 9'd37, 4'd1, 5'd7}},
      // leap day of a 400-divisible century: Tuesday 2000-02-29
      '{32'd951782400, 1'b1, '{6'd0, 6'd0, 5'd0, 3'd2, 8'd100, 9'd59, 4'd1, 5'd29}},
      '{32'd31535999, 1'b0, '0},     // last second of 1970
      '{32'd31536000, 1'b0, '0},
      '{32'd68083200, 1'b0, '0},     // 1972 Feb 28, 29, Mar 1
      '{32'd68169600, 1'b0, '0},
      '{32'd68256000, 1'b0, '0},
      '{32'd94694399, 1'b0, '0},     // day 365 of a leap year
      '{32'd946684799, 1'b0, '0},
      '{32'd946684800, 1'b0, '0},
      '{32'd978307199, 1'b0, '0},
      '{32'd4107456000, 1'b0, '0},   // 2100 is not leap: Feb 28 then Mar 1
      '{32'd4107542400, 1'b0, '0},
      '{32'h7FFF_FFFF, 1'b0, '0},
      '{32'h8000_0000, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].secs,
                   dir_rows[i].typed ? dir_rows[i].want : calendar_of(dir_rows[i].secs));
    end

    for (int unsigned k = 0; k < RANDOM_REQUESTS; k++) begin
      kind = $urandom_range(0, 9);
      secs = $urandom();
      if (kind >= 6 && kind <= 7) begin
        // land near year ends and the leap day of a random year
        yr = $urandom_range(EPOCH_YEAR, LAST_FULL_YR);
        cand = 0;
        for (y = EPOCH_YEAR; y < yr; y++) cand += gregorian_leap(y) ? 366 : 365;
        case ($urandom_range(0, 5))
          0: yd = 0;
          1: yd = 58;
          2: yd = 59;
          3: yd = 60;
          4: yd = gregorian_leap(yr) ? 365 : 364;
          default: yd = $urandom_range(0, 364);
        endcase
        cand = cand * SECS_PER_DAY + yd * SECS_PER_DAY;
        cand += $urandom_range(0, 1) ? $urandom_range(0, SECS_PER_DAY - 1)
                                     : ($urandom_range(0, 1) ? 0 : SECS_PER_DAY - 1);
        if (cand <= 64'hFFFF_FFFF) secs = 32'(cand);
      end else if (kind == 8) begin
        secs = $urandom_range(0, 100_000_000);
      end else if (kind == 9) begin
        secs = 32'hFFFF_FFFF - $urandom_range(0, 40_000_000);
      end
      send_request(secs, calendar_of(secs));
    end
    in_valid <= 1'b0;

    while (cal_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests converted and checked, years %0d to %0d (since 1900)",
             results_seen, min_year, max_year);
    $display("%0d leap days hit, one long output hold with the input backed up",
             leap_days_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
